FILE: design/bwu_pkg.sv
// Package for the breakpoint/watchpoint unit: item kinds, field widths,
// default parameters and the structs passed between the submodules. No dependencies.
`timescale 1ns / 1ps

package bwu_pkg;

  localparam int KIND_W       = 3;
  localparam int ADDR_W       = 12;
  localparam int ENTRIES_W    = 5;
  localparam int S_TDATA_W    = 16;
  localparam int M_TDATA_W    = 16;

  localparam int DEF_ENTRIES   = 16;
  localparam int DEF_ADDR_BITS = 12;

  localparam logic [KIND_W-1:0] KIND_TOG_CODE = 3'd0;
  localparam logic [KIND_W-1:0] KIND_TOG_MEM  = 3'd1;
  localparam logic [KIND_W-1:0] KIND_CLEAR    = 3'd2;
  localparam logic [KIND_W-1:0] KIND_FETCH    = 3'd3;
  localparam logic [KIND_W-1:0] KIND_DATA     = 3'd4;
  localparam logic [KIND_W-1:0] KIND_RUNSTOP  = 3'd5;
  localparam logic [KIND_W-1:0] KIND_STEP     = 3'd6;
  localparam logic [KIND_W-1:0] KIND_RELOAD   = 3'd7;

  typedef struct packed {
    logic hit;
    logic present;
    logic full;
  } tbl_res_t;

  typedef struct packed {
    logic execute;
    logic halted;
  } ctrl_res_t;

endpackage

FILE: design/bwu_table.sv
// Breakpoint table: entry storage, parallel address compare, lowest free slot
// search and the valid-entry count. Depends on bwu_pkg.
`timescale 1ns / 1ps

module bwu_table #(
  parameter int ENTRIES   = bwu_pkg::DEF_ENTRIES,
  parameter int ADDR_BITS = bwu_pkg::DEF_ADDR_BITS
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           en,
  input  logic [bwu_pkg::KIND_W-1:0]     kind,
  input  logic [ADDR_BITS-1:0]           addr,
  output bwu_pkg::tbl_res_t              res,
  output logic [bwu_pkg::ENTRIES_W-1:0]  entries
);

  localparam int CW = $clog2(ENTRIES + 1);
  localparam int EW = (CW > bwu_pkg::ENTRIES_W) ? CW : bwu_pkg::ENTRIES_W;

  logic [ADDR_BITS-1:0] entry_address [ENTRIES];
  logic                 entry_is_memory [ENTRIES];
  logic [ENTRIES-1:0]   valid;
  logic [ENTRIES-1:0]   valid_next;
  logic [CW-1:0]        count;
  logic [CW-1:0]        count_next;

  logic [ENTRIES-1:0]   match_vec;
  logic [ENTRIES-1:0]   free_vec;
  logic [ENTRIES-1:0]   slot_oh;
  logic                 is_mem;
  logic                 toggle;
  logic                 hit;
  logic                 full;
  logic                 insert;
  logic [EW-1:0]        count_ext;

  assign is_mem = (kind == bwu_pkg::KIND_TOG_MEM) || (kind == bwu_pkg::KIND_DATA);
  assign toggle = (kind == bwu_pkg::KIND_TOG_CODE) || (kind == bwu_pkg::KIND_TOG_MEM);

  always_comb begin
    for (int i = 0; i < ENTRIES; i++) begin
      match_vec[i] = valid[i] && (entry_address[i] == addr) && (entry_is_memory[i] == is_mem);
    end
  end

  assign hit      = |match_vec;
  assign free_vec = ~valid;
  assign slot_oh  = free_vec & (~free_vec + {{(ENTRIES-1){1'b0}}, 1'b1});
  assign full     = ~|free_vec;
  assign insert   = toggle && !hit && !full;

  always_comb begin
    valid_next = valid;
    count_next = count;
    if (toggle) begin
      if (hit) begin
        valid_next = valid & ~match_vec;
        count_next = count - CW'(1);
      end else if (!full) begin
        valid_next = valid | slot_oh;
        count_next = count + CW'(1);
      end
    end else if (kind == bwu_pkg::KIND_CLEAR) begin
      valid_next = '0;
      count_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
      count <= '0;
    end else if (en) begin
      valid <= valid_next;
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < ENTRIES; i++) begin
      if (en && insert && slot_oh[i]) begin
        entry_address[i]   <= addr;
        entry_is_memory[i] <= is_mem;
      end
    end
  end

  assign count_ext   = EW'(count_next);
  assign entries     = count_ext[bwu_pkg::ENTRIES_W-1:0];
  assign res.hit     = hit;
  assign res.present = insert;
  assign res.full    = toggle && !hit && full;

endmodule

FILE: design/bwu_ctrl.sv
// Run control: pause flag, pending single step and last-break marker.
// Depends on bwu_pkg.
`timescale 1ns / 1ps

module bwu_ctrl #(
  parameter int ADDR_BITS = bwu_pkg::DEF_ADDR_BITS
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       en,
  input  logic [bwu_pkg::KIND_W-1:0] kind,
  input  logic [ADDR_BITS-1:0]       addr,
  input  logic                       hit,
  output bwu_pkg::ctrl_res_t         res
);

  logic                 paused;
  logic                 paused_next;
  logic                 step_pending;
  logic                 step_pending_next;
  logic [ADDR_BITS-1:0] last_break_address;
  logic [ADDR_BITS-1:0] last_break_address_next;
  logic                 last_break_valid;
  logic                 last_break_valid_next;
  logic                 execute;

  always_comb begin
    paused_next             = paused;
    step_pending_next       = step_pending;
    last_break_address_next = last_break_address;
    last_break_valid_next   = last_break_valid;
    execute                 = 1'b0;
    case (kind)
      bwu_pkg::KIND_FETCH: begin
        // a code breakpoint does not pause again at the marked address until a step or reload clears the marker
        if (hit && !(last_break_valid && (last_break_address == addr))) begin
          paused_next             = 1'b1;
          step_pending_next       = 1'b0;
          last_break_address_next = addr;
          last_break_valid_next   = 1'b1;
        end
        if (!paused_next) begin
          execute = 1'b1;
        end else if (step_pending_next) begin
          execute               = 1'b1;
          step_pending_next     = 1'b0;
          last_break_valid_next = 1'b0;
        end
      end
      bwu_pkg::KIND_DATA: begin
        if (hit) begin
          paused_next       = 1'b1;
          step_pending_next = 1'b0;
        end
      end
      bwu_pkg::KIND_RUNSTOP: begin
        paused_next = ~paused;
      end
      bwu_pkg::KIND_STEP: begin
        paused_next       = 1'b1;
        step_pending_next = 1'b1;
      end
      bwu_pkg::KIND_RELOAD: begin
        paused_next           = 1'b1;
        step_pending_next     = 1'b0;
        last_break_valid_next = 1'b0;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      paused             <= 1'b0;
      step_pending       <= 1'b0;
      last_break_address <= '0;
      last_break_valid   <= 1'b0;
    end else if (en) begin
      paused             <= paused_next;
      step_pending       <= step_pending_next;
      last_break_address <= last_break_address_next;
      last_break_valid   <= last_break_valid_next;
    end
  end

  assign res.execute = execute;
  assign res.halted  = paused_next;

endmodule

FILE: design/breakpoint_watchpoint_unit.sv
// Top level of the debug breakpoint/watchpoint unit: input register, table
// and run control, result register. Depends on bwu_pkg, bwu_table, bwu_ctrl.
//
//   channel  dir  tdata (low bit up)                                 tuser
//   s_axis   in   addr[11:0], zero[15:12]                             kind[2:0]
//   m_axis   out  execute, halted, hit, present, full_res, entries[4:0], zero
//
// One beat per cycle sustained while m_axis accepts; each beat passes the input
// register, one compare pass and then the result register before it is on m_axis.
// rst is synchronous: the table empties, the core runs, no step and no marker.
// A stall on m_axis holds the result register; s_tready then drops once the
// input register is also occupied.
`timescale 1ns / 1ps

module breakpoint_watchpoint_unit #(
  parameter int ENTRIES   = bwu_pkg::DEF_ENTRIES,
  parameter int ADDR_BITS = bwu_pkg::DEF_ADDR_BITS
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  input  logic [bwu_pkg::S_TDATA_W-1:0]   s_tdata,  // addr[11:0], zero pad
  input  logic [bwu_pkg::KIND_W-1:0]      s_tuser,  // kind[2:0]
  output logic                            m_tvalid,
  input  logic                            m_tready,
  output logic [bwu_pkg::M_TDATA_W-1:0]   m_tdata   // execute, halted, hit, present,
                                                     // full_res, entries[4:0], zero pad
);

  logic                            in_valid;
  logic [bwu_pkg::KIND_W-1:0]      in_kind;
  logic [bwu_pkg::ADDR_W-1:0]      in_addr;
  logic [ADDR_BITS-1:0]            a;
  logic                            advance;

  bwu_pkg::tbl_res_t               tbl_res;
  bwu_pkg::ctrl_res_t              ctrl_res;
  logic [bwu_pkg::ENTRIES_W-1:0]   entries;
  logic                            is_hit_kind;
  logic                            is_toggle;

  logic                            out_valid;
  logic [bwu_pkg::M_TDATA_W-1:0]   out_data;
  logic [bwu_pkg::M_TDATA_W-1:0]   out_data_next;

  assign advance  = in_valid && (!out_valid || m_tready);
  assign s_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_kind <= s_tuser;
      in_addr <= s_tdata[bwu_pkg::ADDR_W-1:0];
    end
  end

  assign a = ADDR_BITS'(in_addr);

  bwu_table #(
    .ENTRIES   (ENTRIES),
    .ADDR_BITS (ADDR_BITS)
  ) u_table (
    .clk     (clk),
    .rst     (rst),
    .en      (advance),
    .kind    (in_kind),
    .addr    (a),
    .res     (tbl_res),
    .entries (entries)
  );

  bwu_ctrl #(
    .ADDR_BITS (ADDR_BITS)
  ) u_ctrl (
    .clk  (clk),
    .rst  (rst),
    .en   (advance),
    .kind (in_kind),
    .addr (a),
    .hit  (tbl_res.hit),
    .res  (ctrl_res)
  );

  assign is_toggle   = (in_kind == bwu_pkg::KIND_TOG_CODE) ||
                       (in_kind == bwu_pkg::KIND_TOG_MEM);
  assign is_hit_kind = is_toggle || (in_kind == bwu_pkg::KIND_FETCH) ||
                       (in_kind == bwu_pkg::KIND_DATA);

  always_comb begin
    out_data_next      = '0;
    out_data_next[0]   = ctrl_res.execute;
    out_data_next[1]   = ctrl_res.halted;
    out_data_next[2]   = tbl_res.hit && is_hit_kind;
    out_data_next[3]   = tbl_res.present;
    out_data_next[4]   = tbl_res.full;
    out_data_next[9:5] = entries;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_data <= out_data_next;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = out_data;

endmodule

FILE: dv/tb.sv
// Self-checking bench for breakpoint_watchpoint_unit: a directed table, then random
// traffic; results checked against typed rows or an in-bench predictor.
// Depends on bwu_pkg and the unit's RTL.
`timescale 1ns / 1ps

module tb;

  localparam int NUM_BP       = bwu_pkg::DEF_ENTRIES;
  localparam int RANDOM_BEATS = 1550;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int HOLD_AT      = 400;
  localparam int HOLD_LEN     = 80;
  localparam int QUIET_FROM   = 700;
  localparam int QUIET_TO     = 1000;
  localparam int DRAIN_CYCLES = 10;
  localparam int KW           = bwu_pkg::KIND_W;
  localparam int AW           = bwu_pkg::ADDR_W;

  typedef struct packed {
    logic       execute;
    logic       halted;
    logic       hit;
    logic       present;
    logic       full_res;
    logic [4:0] entries;
  } beat_result_t;

  typedef struct packed {
    logic [KW-1:0] kind;
    logic [AW-1:0] addr;
    logic          typed;
    beat_result_t  want;
  } stim_row_t;

  localparam int DIRECTED_ROWS = 22;

  logic                           clk = 1'b0;
  logic                           rst = 1'b1;
  logic                           s_tvalid = 1'b0;
  logic                           s_tready;
  logic [bwu_pkg::S_TDATA_W-1:0]  s_tdata = '0;
  logic [KW-1:0]                  s_tuser = '0;
  logic                           m_tvalid;
  logic                           m_tready = 1'b0;
  logic [bwu_pkg::M_TDATA_W-1:0]  m_tdata;

  breakpoint_watchpoint_unit dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
  );

  always #6 clk = ~clk;

  // predictor state
  logic [AW-1:0] bp_addr [NUM_BP];
  logic          bp_is_mem [NUM_BP];
  logic          bp_valid [NUM_BP];
  logic          core_paused;
  logic          step_armed;
  logic [AW-1:0] marker_addr;
  logic          marker_valid;
  logic [4:0]    bp_count;

  beat_result_t expected_q[$];
  beat_result_t typed_want;
  bit           use_typed;
  int           sent_count;
  int           result_count;
  int           error_count;
  int           cycle_count;
  int           hits_seen, refused_inserts, held_fetches;
  logic [AW-1:0] addr_pool [12];

  stim_row_t directed_rows [DIRECTED_ROWS] = '{
    '{bwu_pkg::KIND_FETCH,    12'h000, 1'b1, '{1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 5'd0}},
    '{bwu_pkg::KIND_FETCH,    12'hfff, 1'b1, '{1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 5'd0}},
    '{bwu_pkg::KIND_TOG_CODE, 12'h000, 1'b1, '{1'b0, 1'b0, 1'b0, 1'b1, 1'b0, 5'd1}},
    '{bwu_pkg::KIND_TOG_MEM,  12'hfff, 1'b1, '{1'b0, 1'b0, 1'b0, 1'b1, 1'b0, 5'd2}},
    '{bwu_pkg::KIND_FETCH,    12'h000, 1'b0, '0},
    '{bwu_pkg::KIND_FETCH,    12'h000, 1'b0, '0},
    '{bwu_pkg::KIND_STEP,     12'h5a5, 1'b0, '0},
    '{bwu_pkg::KIND_FETCH,    12'h000, 1'b0, '0},
    '{bwu_pkg::KIND_FETCH,    12'h000, 1'b0, '0},
    '{bwu_pkg::KIND_STEP,     12'ha5a, 1'b0, '0},
    '{bwu_pkg::KIND_RUNSTOP,  12'hfff, 1'b0, '0},
    '{bwu_pkg::KIND_FETCH,    12'h123, 1'b0, '0},
    '{bwu_pkg::KIND_DATA,     12'hfff, 1'b0, '0},
    '{bwu_pkg::KIND_DATA,     12'h000, 1'b0, '0},
    '{bwu_pkg::KIND_FETCH,    12'hfff, 1'b0, '0},
    '{bwu_pkg::KIND_RELOAD,   12'h000, 1'b0, '0},
    '{bwu_pkg::KIND_RUNSTOP,  12'h000, 1'b0, '0},
    '{bwu_pkg::KIND_FETCH,    12'h000, 1'b0, '0},
    '{bwu_pkg::KIND_RUNSTOP,  12'h800, 1'b0, '0},
    '{bwu_pkg::KIND_FETCH,    12'h000, 1'b0, '0},
    '{bwu_pkg::KIND_TOG_CODE, 12'h000, 1'b1, '{1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 5'd1}},
    '{bwu_pkg::KIND_CLEAR,    12'h7ff, 1'b1, '{1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 5'd0}}
  };

  function automatic logic table_match(input logic [AW-1:0] a, input logic is_mem);
    logic m;
    m = 1'b0;
    for (int i = 0; i < NUM_BP; i++)
      if (bp_valid[i] && bp_addr[i] == a && bp_is_mem[i] == is_mem) m = 1'b1;
    return m;
  endfunction

  function automatic beat_result_t predict_beat(input logic [KW-1:0] k,
                                                input logic [AW-1:0] a);
    beat_result_t r;
    int           slot;
    logic         is_mem;
    r = '0;
    slot = -1;
    is_mem = (k == bwu_pkg::KIND_TOG_MEM);
    case (k)
      bwu_pkg::KIND_TOG_CODE, bwu_pkg::KIND_TOG_MEM: begin
        if (table_match(a, is_mem)) begin
          r.hit = 1'b1;
          for (int i = 0; i < NUM_BP; i++)
            if (bp_valid[i] && bp_addr[i] == a && bp_is_mem[i] == is_mem) bp_valid[i] = 1'b0;
        end else begin
          for (int i = 0; i < NUM_BP; i++)
            if (!bp_valid[i] && slot < 0) slot = i;
          if (slot < 0) begin
            r.full_res = 1'b1;
            refused_inserts++;
          end else begin
            bp_valid[slot]  = 1'b1;
            bp_addr[slot]   = a;
            bp_is_mem[slot] = is_mem;
            r.present = 1'b1;
          end
        end
      end
      bwu_pkg::KIND_CLEAR: begin
        for (int i = 0; i < NUM_BP; i++) bp_valid[i] = 1'b0;
      end
      bwu_pkg::KIND_FETCH: begin
        if (table_match(a, 1'b0)) begin
          r.hit = 1'b1;
          if (!(marker_valid && marker_addr == a)) begin
            core_paused  = 1'b1;
            step_armed   = 1'b0;
            marker_addr  = a;
            marker_valid = 1'b1;
          end
        end
        if (!core_paused) begin
          r.execute = 1'b1;
        end else if (step_armed) begin
          r.execute    = 1'b1;
          step_armed   = 1'b0;
          marker_valid = 1'b0;
        end else begin
          held_fetches++;
        end
      end
      bwu_pkg::KIND_DATA: begin
        if (table_match(a, 1'b1)) begin
          r.hit       = 1'b1;
          core_paused = 1'b1;
          step_armed  = 1'b0;
        end
      end
      bwu_pkg::KIND_RUNSTOP: core_paused = ~core_paused;
      bwu_pkg::KIND_STEP: begin
        core_paused = 1'b1;
        step_armed  = 1'b1;
      end
      bwu_pkg::KIND_RELOAD: begin
        core_paused  = 1'b1;
        step_armed   = 1'b0;
        marker_valid = 1'b0;
      end
      default: ;
    endcase
    r.halted = core_paused;
    bp_count = '0;
    for (int i = 0; i < NUM_BP; i++) bp_count += bp_valid[i];
    r.entries = bp_count;
    if (r.hit) hits_seen++;
    return r;
  endfunction

  task automatic flag_mismatch(input string what, input int got, input int want);
    if (got != want) begin
      $display("MISMATCH result %0d: %s got %0d expected %0d", result_count, what, got, want);
      error_count++;
    end
  endtask

  // entered and left at a falling edge
  task automatic send_beat(input logic [KW-1:0] k, input logic [AW-1:0] a);
    beat_result_t want;
    while (!(sent_count >= QUIET_FROM && sent_count < QUIET_TO) && $urandom_range(99) < 34) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= k;
    s_tdata  <= {{(bwu_pkg::S_TDATA_W-AW){1'b0}}, a};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    want = predict_beat(k, a);
    if (use_typed) want = typed_want;
    expected_q = {expected_q, want};
    sent_count++;
    @(negedge clk);
  endtask

  function automatic logic [AW-1:0] pick_addr();
    if ($urandom_range(99) < 80) return addr_pool[$urandom_range(11)];
    return AW'($urandom_range(4095));
  endfunction

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // receiver: random stalls, one long hold-off, a quiet stretch
  int hold_left = 0;
  bit hold_done = 0;
  always @(negedge clk) begin
    if (!hold_done && sent_count >= HOLD_AT) begin
      hold_left = HOLD_LEN;
      hold_done = 1;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_tready <= 1'b0;
    end else if (sent_count >= QUIET_FROM && sent_count < QUIET_TO) begin
      m_tready <= 1'b1;
    end else begin
      m_tready <= ($urandom_range(99) >= 34);
    end
  end

  always @(posedge clk) begin
    beat_result_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (expected_q.size() == 0) begin
        flag_mismatch("beat with nothing expected", 1, 0);
      end else begin
        want = expected_q.pop_front();
        flag_mismatch("execute",  m_tdata[0],   want.execute);
        flag_mismatch("halted",   m_tdata[1],   want.halted);
        flag_mismatch("hit",      m_tdata[2],   want.hit);
        flag_mismatch("present",  m_tdata[3],   want.present);
        flag_mismatch("full_res", m_tdata[4],   want.full_res);
        flag_mismatch("entries",  m_tdata[9:5], want.entries);
        flag_mismatch("pad",      m_tdata[bwu_pkg::M_TDATA_W-1:10], 0);
      end
      result_count++;
    end
  end

  initial begin
    int sel;
    for (int i = 0; i < NUM_BP; i++) begin
      bp_addr[i]   = '0;
      bp_is_mem[i] = 1'b0;
      bp_valid[i]  = 1'b0;
    end
    core_paused = 1'b0;
    step_armed = 1'b0;
    marker_addr = '0;
    marker_valid = 1'b0;
    bp_count = '0;
    addr_pool[0] = 12'h000;
    addr_pool[1] = 12'hfff;
    addr_pool[2] = 12'h001;
    addr_pool[3] = 12'h800;
    addr_pool[4] = 12'h7ff;
    for (int i = 5; i < 12; i++) addr_pool[i] = AW'($urandom_range(4095));

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    for (int r = 0; r < DIRECTED_ROWS; r++) begin
      use_typed  = directed_rows[r].typed;
      typed_want = directed_rows[r].want;
      send_beat(directed_rows[r].kind, directed_rows[r].addr);
    end
    use_typed = 0;

    while (sent_count < DIRECTED_ROWS + RANDOM_BEATS) begin
      sel = $urandom_range(99);
      if (sel < 45) begin
        // debug session: fetches and data accesses, stepping or run/stop through pauses
        repeat ($urandom_range(20, 4)) begin
          if (core_paused && $urandom_range(99) < 55)
            send_beat(bwu_pkg::KIND_STEP, AW'($urandom_range(4095)));
          else if (core_paused && $urandom_range(99) < 25)
            send_beat(bwu_pkg::KIND_RUNSTOP, AW'($urandom_range(4095)));
          else if ($urandom_range(99) < 20)
            send_beat(bwu_pkg::KIND_DATA, pick_addr());
          else
            send_beat(bwu_pkg::KIND_FETCH, pick_addr());
        end
      end else if (sel < 65) begin
        repeat ($urandom_range(6, 1))
          send_beat($urandom_range(1) ? bwu_pkg::KIND_TOG_MEM : bwu_pkg::KIND_TOG_CODE,
                    pick_addr());
      end else if (sel < 73) begin
        // fill the table and push past it
        repeat (18 - int'(bp_count) + $urandom_range(2))
          send_beat($urandom_range(1) ? bwu_pkg::KIND_TOG_MEM : bwu_pkg::KIND_TOG_CODE,
                    AW'($urandom_range(4095)));
      end else if (sel < 90) begin
        repeat ($urandom_range(8, 1))
          send_beat(KW'($urandom_range(7)), AW'($urandom_range(4095)));
      end else begin
        case ($urandom_range(2))
          0:       send_beat(bwu_pkg::KIND_CLEAR, pick_addr());
          1:       send_beat(bwu_pkg::KIND_RELOAD, pick_addr());
          default: send_beat(bwu_pkg::KIND_RUNSTOP, pick_addr());
        endcase
      end
    end
    s_tvalid <= 1'b0;

    while (expected_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Ran %0d beats: %0d breakpoint hits, %0d inserts refused on a full table,",
             sent_count, hits_seen, refused_inserts);
    $display("%0d fetches held while paused, one long sink hold-off.", held_fetches);
    if (error_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
